// ----- sv/im2col_pkg.sv -----
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared widths, register codes, control structs and helper functions for
// the im2col copy-address generator.
// ----------------------------------------------------------------------------
package im2col_pkg;

  // Width of the emitted source and destination indices
  localparam int unsigned IdxW     = 32;
  // Configuration port widths
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 11;
  // Count registers (1..1024) and small registers (1..15)
  localparam int unsigned CountW   = 11;
  localparam int unsigned SmallW   = 4;
  // Loop counter widths
  localparam int unsigned LoopW    = 10;
  localparam int unsigned MaxCount = 1024;

  // Register indexes of the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    REG_CHANNELS      = 4'd0,
    REG_IN_HEIGHT     = 4'd1,
    REG_IN_WIDTH      = 4'd2,
    REG_KERNEL_HEIGHT = 4'd3,
    REG_KERNEL_WIDTH  = 4'd4,
    REG_STRIDES       = 4'd5,
    REG_OUT_HEIGHT    = 4'd6,
    REG_OUT_WIDTH     = 4'd7
  } cfg_reg_e;

  // Effective register values (zero already mapped to one, counts clamped)
  typedef struct packed {
    logic [CountW-1:0] channels;
    logic [CountW-1:0] in_height;
    logic [CountW-1:0] in_width;
    logic [CountW-1:0] out_height;
    logic [CountW-1:0] out_width;
    logic [SmallW-1:0] kernel_height;
    logic [SmallW-1:0] kernel_width;
    logic [SmallW-1:0] stride_x;
    logic [SmallW-1:0] stride_y;
  } cfg_regs_t;

  // Settle sequencer status toward the datapath
  typedef struct packed {
    logic busy;    // step products not yet valid, hold off input
    logic reload;  // recompute counter terms from counter values
  } cfg_ctl_t;

  // Map a count register write to its effective value
  function automatic logic [CountW-1:0] eff_count(input logic [CfgDataW-1:0] value);
    logic [CountW-1:0] result;
    if (value == '0) begin
      result = CountW'(1);
    end else if (value > CfgDataW'(MaxCount)) begin
      result = CountW'(MaxCount);
    end else begin
      result = CountW'(value);
    end
    return result;
  endfunction

  // Map a kernel size or stride nibble to its effective value
  function automatic logic [SmallW-1:0] eff_small(input logic [SmallW-1:0] value);
    logic [SmallW-1:0] result;
    result = (value == '0) ? SmallW'(1) : value;
    return result;
  endfunction

endpackage

// ----- sv/im2col_in_if.sv -----
// ----------------------------------------------------------------------------
// im2col_in_if
// Request channel: one transaction asks for one address pair.
// ----------------------------------------------------------------------------
interface im2col_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- sv/im2col_out_if.sv -----
// ----------------------------------------------------------------------------
// im2col_out_if
// Result channel: source index, destination index and last flag.
// ----------------------------------------------------------------------------
interface im2col_out_if;
  logic                        valid;
  logic                        ready;
  logic [im2col_pkg::IdxW-1:0] source_index;
  logic [im2col_pkg::IdxW-1:0] dest_index;
  logic                        last;

  modport source (output valid, output source_index, output dest_index, output last,
                  input ready);
  modport sink   (input valid, input source_index, input dest_index, input last,
                  output ready);
endinterface

// ----- sv/im2col_cfg_if.sv -----
// ----------------------------------------------------------------------------
// im2col_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface im2col_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [im2col_pkg::CfgAddrW-1:0] index;
  logic [im2col_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/im2col_address_generator_core.sv -----
// ----------------------------------------------------------------------------
// im2col_address_generator_core
// Emits one source/destination address pair per request for copying a CHW
// tensor into an im2col column matrix.
//
//   channel  dir   payload                              transaction
//   in_ch    sink  restart                              one pair request
//   out_ch   src   source_index, dest_index, last       one address pair
//   cfg_ch   sink  index (4 b), data (11 b)             one register write
//
// One request per cycle sustained while the settle sequencer is idle and
// out_ch takes each result; a request passes the input register, then the
// result register. After reset and after every register write, in_ch.ready
// stays low while the step products pass two multiplier stages and the loop
// terms reload. cfg_ch.ready is always high.
// A stalled result holds in the output register; the input register takes
// one more request behind it, then ready drops.
// ----------------------------------------------------------------------------
module im2col_address_generator_core #(
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  im2col_in_if.sink     in_ch,
  im2col_out_if.source  out_ch,
  im2col_cfg_if.sink    cfg_ch
);

  localparam int unsigned TermW =
    (ADDRESS_WIDTH < im2col_pkg::IdxW) ? ADDRESS_WIDTH : im2col_pkg::IdxW;
  localparam int unsigned NumLoops = 5;

  im2col_pkg::cfg_regs_t regs;
  im2col_pkg::cfg_ctl_t  ctl;

  logic [TermW-1:0] plane, row_step, out_plane, kcol_plane, chan_plane;
  logic [TermW-1:0] iw_w, sx_w, ow_w, one_w;

  logic in_valid_q, in_valid_d, restart_q, in_ready, in_accept, advance;
  logic out_valid_q, out_valid_d, last_q;
  logic [im2col_pkg::IdxW-1:0] src_q, dst_q;

  logic [TermW-1:0]    src_term [NumLoops];
  logic [TermW-1:0]    dst_term [NumLoops];
  logic [NumLoops-1:0] at_end;
  logic                kc_carry, kr_carry, ch_carry, oc_carry;
  logic [TermW-1:0]    src_sum, dst_sum;

  // Configuration and step products
  im2col_cfg #(
    .TermW (TermW)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_valid_i   (cfg_ch.valid),
    .wr_index_i   (cfg_ch.index),
    .wr_data_i    (cfg_ch.data),
    .regs_o       (regs),
    .ctl_o        (ctl),
    .plane_o      (plane),
    .row_step_o   (row_step),
    .out_plane_o  (out_plane),
    .kcol_plane_o (kcol_plane),
    .chan_plane_o (chan_plane)
  );

  assign cfg_ch.ready = 1'b1;

  assign iw_w  = TermW'(regs.in_width);
  assign sx_w  = TermW'(regs.stride_x);
  assign ow_w  = TermW'(regs.out_width);
  assign one_w = TermW'(1);

  // Handshake: input register moves on when the result register frees up
  assign advance   = in_valid_q & (~out_valid_q | out_ch.ready);
  assign in_ready  = ~ctl.busy & (~in_valid_q | advance);
  assign in_accept = in_ch.valid & in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      restart_q <= in_ch.restart;
    end
  end

  // Loop nest, innermost first: kernel column, kernel row, channel,
  // output column, output row
  im2col_cnt #(.CntW(im2col_pkg::SmallW), .TermW(TermW)) u_kcol (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (im2col_pkg::CountW'(regs.kernel_width)),
    .src_step_i (one_w),
    .dst_step_i (out_plane),
    .reload_i   (ctl.reload),
    .advance_i  (advance),
    .restart_i  (restart_q),
    .carry_i    (1'b1),
    .src_term_o (src_term[0]),
    .dst_term_o (dst_term[0]),
    .at_end_o   (at_end[0]),
    .carry_o    (kc_carry)
  );

  im2col_cnt #(.CntW(im2col_pkg::SmallW), .TermW(TermW)) u_krow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (im2col_pkg::CountW'(regs.kernel_height)),
    .src_step_i (iw_w),
    .dst_step_i (kcol_plane),
    .reload_i   (ctl.reload),
    .advance_i  (advance),
    .restart_i  (restart_q),
    .carry_i    (kc_carry),
    .src_term_o (src_term[1]),
    .dst_term_o (dst_term[1]),
    .at_end_o   (at_end[1]),
    .carry_o    (kr_carry)
  );

  im2col_cnt #(.CntW(im2col_pkg::LoopW), .TermW(TermW)) u_chan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (regs.channels),
    .src_step_i (plane),
    .dst_step_i (chan_plane),
    .reload_i   (ctl.reload),
    .advance_i  (advance),
    .restart_i  (restart_q),
    .carry_i    (kr_carry),
    .src_term_o (src_term[2]),
    .dst_term_o (dst_term[2]),
    .at_end_o   (at_end[2]),
    .carry_o    (ch_carry)
  );

  im2col_cnt #(.CntW(im2col_pkg::LoopW), .TermW(TermW)) u_ocol (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (regs.out_width),
    .src_step_i (sx_w),
    .dst_step_i (one_w),
    .reload_i   (ctl.reload),
    .advance_i  (advance),
    .restart_i  (restart_q),
    .carry_i    (ch_carry),
    .src_term_o (src_term[3]),
    .dst_term_o (dst_term[3]),
    .at_end_o   (at_end[3]),
    .carry_o    (oc_carry)
  );

  im2col_cnt #(.CntW(im2col_pkg::LoopW), .TermW(TermW)) u_orow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (regs.out_height),
    .src_step_i (row_step),
    .dst_step_i (ow_w),
    .reload_i   (ctl.reload),
    .advance_i  (advance),
    .restart_i  (restart_q),
    .carry_i    (oc_carry),
    .src_term_o (src_term[4]),
    .dst_term_o (dst_term[4]),
    .at_end_o   (at_end[4]),
    .carry_o    ()
  );

  // Sum the loop contributions
  assign src_sum = src_term[0] + src_term[1] + src_term[2] + src_term[3] + src_term[4];
  assign dst_sum = dst_term[0] + dst_term[1] + dst_term[2] + dst_term[3] + dst_term[4];

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      src_q  <= im2col_pkg::IdxW'(src_sum);
      dst_q  <= im2col_pkg::IdxW'(dst_sum);
      last_q <= &at_end;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.source_index = src_q;
  assign out_ch.dest_index   = dst_q;
  assign out_ch.last         = last_q;

endmodule

// ----- sv/im2col_cnt.sv -----
// ----------------------------------------------------------------------------
// im2col_cnt
// One loop counter with its running contributions to the source and
// destination indices (counter value times the per-step increments).
// ----------------------------------------------------------------------------
module im2col_cnt #(
  parameter int unsigned CntW  = 10,
  parameter int unsigned TermW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [im2col_pkg::CountW-1:0] limit_i,
  input  logic [TermW-1:0]              src_step_i,
  input  logic [TermW-1:0]              dst_step_i,
  input  logic                          reload_i,
  input  logic                          advance_i,
  input  logic                          restart_i,
  input  logic                          carry_i,
  output logic [TermW-1:0]              src_term_o,
  output logic [TermW-1:0]              dst_term_o,
  output logic                          at_end_o,
  output logic                          carry_o
);

  logic [CntW-1:0]               cnt_q, cnt_d, cnt_eff;
  logic [TermW-1:0]              src_q, src_d, src_eff;
  logic [TermW-1:0]              dst_q, dst_d, dst_eff;
  logic [TermW-1:0]              cnt_ext;
  logic [im2col_pkg::CountW-1:0] cnt_inc;

  // Restart clears the loop before this transaction uses it
  assign cnt_eff = restart_i ? '0 : cnt_q;
  assign src_eff = restart_i ? '0 : src_q;
  assign dst_eff = restart_i ? '0 : dst_q;
  assign cnt_ext = TermW'(cnt_q);

  // Wrap test: a count at or past its limit minus one wraps when it advances with carry in
  assign cnt_inc  = im2col_pkg::CountW'(cnt_eff) + im2col_pkg::CountW'(1);
  assign at_end_o = (cnt_inc >= limit_i);
  assign carry_o  = carry_i & at_end_o;

  assign src_term_o = src_eff;
  assign dst_term_o = dst_eff;

  // Reload terms after a configuration change, else step the loop
  always_comb begin
    cnt_d = cnt_q;
    src_d = src_q;
    dst_d = dst_q;
    if (reload_i) begin
      src_d = cnt_ext * src_step_i;
      dst_d = cnt_ext * dst_step_i;
    end else if (advance_i) begin
      cnt_d = cnt_eff;
      src_d = src_eff;
      dst_d = dst_eff;
      if (carry_i) begin
        if (at_end_o) begin
          cnt_d = '0;
          src_d = '0;
          dst_d = '0;
        end else begin
          cnt_d = CntW'(cnt_inc);
          src_d = src_eff + src_step_i;
          dst_d = dst_eff + dst_step_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      src_q <= '0;
      dst_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      src_q <= src_d;
      dst_q <= dst_d;
    end
  end

endmodule

// ----- sv/im2col_cfg.sv -----
// ----------------------------------------------------------------------------
// im2col_cfg
// Configuration registers, the derived step products (two multiplier
// stages) and the settle sequencer that reloads the counter terms.
// ----------------------------------------------------------------------------
module im2col_cfg #(
  parameter int unsigned TermW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_valid_i,
  input  logic [im2col_pkg::CfgAddrW-1:0] wr_index_i,
  input  logic [im2col_pkg::CfgDataW-1:0] wr_data_i,
  output im2col_pkg::cfg_regs_t           regs_o,
  output im2col_pkg::cfg_ctl_t            ctl_o,
  output logic [TermW-1:0]                plane_o,
  output logic [TermW-1:0]                row_step_o,
  output logic [TermW-1:0]                out_plane_o,
  output logic [TermW-1:0]                kcol_plane_o,
  output logic [TermW-1:0]                chan_plane_o
);

  localparam int unsigned KernW = 2 * im2col_pkg::SmallW;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_MUL1 = 4'b0010,
    SEQ_MUL2 = 4'b0100,
    SEQ_LOAD = 4'b1000
  } seq_e;

  im2col_pkg::cfg_regs_t regs_q, regs_d;
  seq_e                  seq_q, seq_d;

  logic [TermW-1:0] ih_w, iw_w, oh_w, ow_w, sy_w, kw_w;
  logic [TermW-1:0] plane_q, row_step_q, out_plane_q, kcol_plane_q, chan_plane_q;
  logic [KernW-1:0] kern_area_q;
  logic [TermW-1:0] kern_area_w;

  // Register writes, effective values stored
  always_comb begin
    regs_d = regs_q;
    if (wr_valid_i) begin
      unique case (im2col_pkg::cfg_reg_e'(wr_index_i))
        im2col_pkg::REG_CHANNELS:  regs_d.channels  = im2col_pkg::eff_count(wr_data_i);
        im2col_pkg::REG_IN_HEIGHT: regs_d.in_height = im2col_pkg::eff_count(wr_data_i);
        im2col_pkg::REG_IN_WIDTH:  regs_d.in_width  = im2col_pkg::eff_count(wr_data_i);
        im2col_pkg::REG_KERNEL_HEIGHT: begin
          regs_d.kernel_height = im2col_pkg::eff_small(wr_data_i[im2col_pkg::SmallW-1:0]);
        end
        im2col_pkg::REG_KERNEL_WIDTH: begin
          regs_d.kernel_width = im2col_pkg::eff_small(wr_data_i[im2col_pkg::SmallW-1:0]);
        end
        im2col_pkg::REG_STRIDES: begin
          regs_d.stride_x = im2col_pkg::eff_small(wr_data_i[im2col_pkg::SmallW-1:0]);
          regs_d.stride_y = im2col_pkg::eff_small(wr_data_i[KernW-1:im2col_pkg::SmallW]);
        end
        im2col_pkg::REG_OUT_HEIGHT: regs_d.out_height = im2col_pkg::eff_count(wr_data_i);
        im2col_pkg::REG_OUT_WIDTH:  regs_d.out_width  = im2col_pkg::eff_count(wr_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.channels      <= im2col_pkg::CountW'(1);
      regs_q.in_height     <= im2col_pkg::CountW'(1);
      regs_q.in_width      <= im2col_pkg::CountW'(1);
      regs_q.out_height    <= im2col_pkg::CountW'(1);
      regs_q.out_width     <= im2col_pkg::CountW'(1);
      regs_q.kernel_height <= im2col_pkg::SmallW'(1);
      regs_q.kernel_width  <= im2col_pkg::SmallW'(1);
      regs_q.stride_x      <= im2col_pkg::SmallW'(1);
      regs_q.stride_y      <= im2col_pkg::SmallW'(1);
    end else begin
      regs_q <= regs_d;
    end
  end

  // Zero-extend operands to the index width
  assign ih_w        = TermW'(regs_q.in_height);
  assign iw_w        = TermW'(regs_q.in_width);
  assign oh_w        = TermW'(regs_q.out_height);
  assign ow_w        = TermW'(regs_q.out_width);
  assign sy_w        = TermW'(regs_q.stride_y);
  assign kw_w        = TermW'(regs_q.kernel_width);
  assign kern_area_w = TermW'(kern_area_q);

  // Step products, first and second multiplier stage
  always_ff @(posedge clk_i) begin
    plane_q      <= ih_w * iw_w;
    row_step_q   <= sy_w * iw_w;
    out_plane_q  <= oh_w * ow_w;
    kern_area_q  <= KernW'(regs_q.kernel_height) * KernW'(regs_q.kernel_width);
    kcol_plane_q <= kw_w * out_plane_q;
    chan_plane_q <= kern_area_w * out_plane_q;
  end

  // Settle sequencer: wait out both product stages, then reload terms
  always_comb begin
    seq_d = seq_q;
    if (wr_valid_i) begin
      seq_d = SEQ_MUL1;
    end else begin
      unique case (seq_q)
        SEQ_IDLE: seq_d = SEQ_IDLE;
        SEQ_MUL1: seq_d = SEQ_MUL2;
        SEQ_MUL2: seq_d = SEQ_LOAD;
        SEQ_LOAD: seq_d = SEQ_IDLE;
        default:  seq_d = SEQ_MUL1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= SEQ_MUL1;
    end else begin
      seq_q <= seq_d;
    end
  end

  assign ctl_o.busy   = (seq_q != SEQ_IDLE);
  assign ctl_o.reload = (seq_q == SEQ_LOAD);

  assign regs_o       = regs_q;
  assign plane_o      = plane_q;
  assign row_step_o   = row_step_q;
  assign out_plane_o  = out_plane_q;
  assign kcol_plane_o = kcol_plane_q;
  assign chan_plane_o = chan_plane_q;

endmodule

// ----- sv/im2col_chk.sv -----
// ----------------------------------------------------------------------------
// im2col_chk
// Port-level checks for the im2col address generator, bound to the top.
// ----------------------------------------------------------------------------
module im2col_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_i,
  input logic [im2col_pkg::IdxW-1:0] source_index_i,
  input logic [im2col_pkg::IdxW-1:0] dest_index_i,
  input logic                        last_i
);

  logic       in_acc, out_acc;
  logic [1:0] occ_q, occ_d;

  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;

  // Track requests taken but not yet delivered
  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      occ_d = occ_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // A register write holds off requests while the steps settle
  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i |=> !in_ready_i)
    else $error("request taken right after a register write");

  // No result without a pending request
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != 2'd0)
    else $error("result shown with no pending request");

  // At most two transactions in flight
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_acc |-> occ_q != 2'd2)
    else $error("request taken with both stages full");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(source_index_i)
      && $stable(dest_index_i) && $stable(last_i))
    else $error("stalled result changed");

endmodule

bind im2col_address_generator_core im2col_chk u_im2col_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch.valid),
  .in_ready_i     (in_ch.ready),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .cfg_valid_i    (cfg_ch.valid),
  .cfg_ready_i    (cfg_ch.ready),
  .source_index_i (out_ch.source_index),
  .dest_index_i   (out_ch.dest_index),
  .last_i         (out_ch.last)
);
